@@ rtl/gtf_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Gammatone filter package
// Shared widths, register indexes, datapath commands and saturation helpers.
// ----------------------------------------------------------------------------
package gtf_pkg;

    localparam int MAX_STAGES = 8;
    localparam int STG_IW     = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
    localparam int STG_CW     = $clog2(MAX_STAGES + 1);

    localparam int SMP_W      = 16;
    localparam int COEF_W     = 32;
    localparam int DECAY_W    = 31;
    localparam int GAIN_W     = 16;
    localparam int ORDER_W    = 4;
    localparam int COEF_FRAC  = 30;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int MUL_A_W    = 35;
    localparam int MUL_B_W    = 32;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int ACC_W      = 35;
    localparam int OUT_SUM_W  = 27;

    localparam logic [DECAY_W-1:0] ONE_Q30 = DECAY_W'(1) << COEF_FRAC;

    localparam logic [CFG_IDX_W-1:0] REG_ORDER   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_COS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_SIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN    = 3'd4;

    typedef enum logic [3:0] {
        OP_MD_RE,
        OP_MD_IM,
        OP_ST_RE,
        OP_ST_IM,
        OP_MU_RE,
        OP_MU_IM,
        OP_RC_CC,
        OP_RC_SS,
        OP_RS_CS,
        OP_RS_SC,
        OP_GAIN
    } t_mul_op;

    typedef struct packed {
        logic              load;
        logic              mul_en;
        t_mul_op           op;
        logic [STG_IW-1:0] idx;
        logic              finish;
    } t_dp_cmd;

    function automatic logic signed [COEF_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [COEF_W-1:0] r;
        if ((v[ACC_W-1:COEF_W-1] == '0) || (v[ACC_W-1:COEF_W-1] == '1)) begin
            r = v[COEF_W-1:0];
        end else if (v[ACC_W-1]) begin
            r = {1'b1, {(COEF_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(COEF_W-1){1'b1}}};
        end
        return r;
    endfunction

    function automatic logic signed [SMP_W-1:0] sat16(input logic signed [OUT_SUM_W-1:0] v);
        logic signed [SMP_W-1:0] r;
        if ((v[OUT_SUM_W-1:SMP_W-1] == '0) || (v[OUT_SUM_W-1:SMP_W-1] == '1)) begin
            r = v[SMP_W-1:0];
        end else if (v[OUT_SUM_W-1]) begin
            r = {1'b1, {(SMP_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(SMP_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/gtf_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Gammatone filter controller
// Sequences the mix-down, stage, mix-up, rotation and gain products through
// the shared multiplier, one product per cycle.
// ----------------------------------------------------------------------------
module gtf_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [gtf_pkg::STG_CW-1:0] i_order,
    input  logic                       i_out_free,
    output gtf_pkg::t_dp_cmd           o_cmd
);
    import gtf_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_MD_RE = 13'b0000000000010,
        S_MD_IM = 13'b0000000000100,
        S_ST_RE = 13'b0000000001000,
        S_ST_IM = 13'b0000000010000,
        S_MU_RE = 13'b0000000100000,
        S_MU_IM = 13'b0000001000000,
        S_RC_CC = 13'b0000010000000,
        S_RC_SS = 13'b0000100000000,
        S_RS_CS = 13'b0001000000000,
        S_RS_SC = 13'b0010000000000,
        S_GAIN  = 13'b0100000000000,
        S_FIN   = 13'b1000000000000
    } t_state;

    t_state              r_state, n_state;
    logic [STG_CW-1:0]   r_cnt, n_cnt;
    logic [STG_CW-1:0]   w_cnt_inc;

    assign w_cnt_inc  = r_cnt + STG_CW'(1);
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        o_cmd        = '0;
        o_cmd.op     = OP_MD_RE;
        o_cmd.idx    = r_cnt[STG_IW-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MD_RE;
                end
            end
            S_MD_RE: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.op     = OP_MD_RE;
                n_state      = S_MD_IM;
            end
            S_MD_IM: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.op     = OP_MD_IM;
                n_cnt        = '0;
                n_state      = (i_order == '0) ? S_MU_RE : S_ST_RE;
            end
            S_ST_RE: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.op     = OP_ST_RE;
                n_state      = S_ST_IM;
            end
            S_ST_IM: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.op     = OP_ST_IM;
                n_cnt        = w_cnt_inc;
                n_state      = (w_cnt_inc == i_order) ? S_MU_RE : S_ST_RE;
            end
            S_MU_RE: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.op     = OP_MU_RE;
                n_state      = S_MU_IM;
            end
            S_MU_IM: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.op     = OP_MU_IM;
                n_state      = S_RC_CC;
            end
            S_RC_CC: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.op     = OP_RC_CC;
                n_state      = S_RC_SS;
            end
            S_RC_SS: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.op     = OP_RC_SS;
                n_state      = S_RS_CS;
            end
            S_RS_CS: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.op     = OP_RS_CS;
                n_state      = S_RS_SC;
            end
            S_RS_SC: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.op     = OP_RS_SC;
                n_state      = S_GAIN;
            end
            S_GAIN: begin
                // The mix-up result is settled by now, the rotation products
                // went in between.
                o_cmd.mul_en = 1'b1;
                o_cmd.op     = OP_GAIN;
                n_state      = S_FIN;
            end
            S_FIN: begin
                if (i_out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule
`default_nettype wire

@@ rtl/gtf_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Gammatone filter datapath
// One shared signed multiplier with a registered product, rounding and
// write-back of the stage state, phasor and output register.
// ----------------------------------------------------------------------------
module gtf_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  gtf_pkg::t_dp_cmd                    i_cmd,
    input  logic signed [gtf_pkg::SMP_W-1:0]    i_audio_in,
    input  logic                                i_add_mode,
    input  logic signed [gtf_pkg::SMP_W-1:0]    i_accum_in,
    input  logic        [gtf_pkg::DECAY_W-1:0]  i_decay,
    input  logic signed [gtf_pkg::COEF_W-1:0]   i_rot_cos,
    input  logic signed [gtf_pkg::COEF_W-1:0]   i_rot_sin,
    input  logic signed [gtf_pkg::GAIN_W-1:0]   i_gain,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic signed [gtf_pkg::SMP_W-1:0]    o_audio_out,
    output logic                                o_out_free
);
    import gtf_pkg::*;

    localparam int PX_W = PROD_W + 1;
    localparam logic signed [PX_W-1:0] HALF17 = PX_W'(1) << 16;
    localparam logic signed [PX_W-1:0] HALF25 = PX_W'(1) << 24;
    localparam logic signed [PX_W-1:0] HALF30 = PX_W'(1) << (COEF_FRAC - 1);

    // Stage state and phasor
    logic signed [COEF_W-1:0] r_in_re  [MAX_STAGES];
    logic signed [COEF_W-1:0] r_in_im  [MAX_STAGES];
    logic signed [COEF_W-1:0] r_out_re [MAX_STAGES];
    logic signed [COEF_W-1:0] r_out_im [MAX_STAGES];
    logic signed [COEF_W-1:0] r_pc;
    logic signed [COEF_W-1:0] r_ps;

    // Per-item working registers
    logic signed [SMP_W-1:0]  r_x;
    logic                     r_add;
    logic signed [SMP_W-1:0]  r_acc;
    logic signed [COEF_W-1:0] r_zr;
    logic signed [COEF_W-1:0] r_zi;
    logic signed [COEF_W-1:0] r_prev;
    logic signed [ACC_W-1:0]  r_t;
    logic signed [ACC_W-1:0]  r_rcos;
    logic signed [ACC_W-1:0]  r_rsin;
    logic signed [PROD_W-1:0] r_prod;
    t_mul_op                  r_wb_op;
    logic [STG_IW-1:0]        r_wb_idx;
    logic                     r_wb_en;
    logic                     r_out_valid;
    logic signed [SMP_W-1:0]  r_out_data;

    logic signed [MUL_A_W-1:0] w_a;
    logic signed [MUL_B_W-1:0] w_b;
    logic signed [COEF_W:0]    w_diff;
    logic signed [COEF_W-1:0]  w_in_sel;
    logic signed [COEF_W-1:0]  w_out_sel;
    logic signed [PX_W-1:0]    w_pext;
    logic signed [PX_W-1:0]    w_rnd17;
    logic signed [PX_W-1:0]    w_rnd25;
    logic signed [PX_W-1:0]    w_rnd30;
    logic signed [ACC_W-1:0]   w_r30;
    logic signed [ACC_W-1:0]   w_st_sum;
    logic signed [COEF_W-1:0]  w_st_new;
    logic signed [OUT_SUM_W-1:0] w_y;

    // Operand selection for the shared multiplier
    always_comb begin
        w_in_sel  = (i_cmd.op == OP_ST_IM) ? r_in_im[i_cmd.idx]  : r_in_re[i_cmd.idx];
        w_out_sel = (i_cmd.op == OP_ST_IM) ? r_out_im[i_cmd.idx] : r_out_re[i_cmd.idx];
        w_diff    = {w_in_sel[COEF_W-1], w_in_sel} - {w_out_sel[COEF_W-1], w_out_sel};
        w_a       = {{(MUL_A_W-COEF_W){r_pc[COEF_W-1]}}, r_pc};
        w_b       = {{(MUL_B_W-SMP_W){r_x[SMP_W-1]}}, r_x};
        case (i_cmd.op)
            OP_MD_RE: begin
                w_a = {{(MUL_A_W-COEF_W){r_pc[COEF_W-1]}}, r_pc};
                w_b = {{(MUL_B_W-SMP_W){r_x[SMP_W-1]}}, r_x};
            end
            OP_MD_IM: begin
                w_a = {{(MUL_A_W-COEF_W){r_ps[COEF_W-1]}}, r_ps};
                w_b = {{(MUL_B_W-SMP_W){r_x[SMP_W-1]}}, r_x};
            end
            OP_ST_RE, OP_ST_IM: begin
                w_a = {{(MUL_A_W-COEF_W-1){w_diff[COEF_W]}}, w_diff};
                w_b = {{(MUL_B_W-DECAY_W){1'b0}}, i_decay};
            end
            OP_MU_RE: begin
                w_a = {{(MUL_A_W-COEF_W){r_zr[COEF_W-1]}}, r_zr};
                w_b = r_pc;
            end
            OP_MU_IM: begin
                w_a = {{(MUL_A_W-COEF_W){r_zi[COEF_W-1]}}, r_zi};
                w_b = r_ps;
            end
            OP_RC_CC: begin
                w_a = {{(MUL_A_W-COEF_W){r_pc[COEF_W-1]}}, r_pc};
                w_b = i_rot_cos;
            end
            OP_RC_SS: begin
                w_a = {{(MUL_A_W-COEF_W){r_ps[COEF_W-1]}}, r_ps};
                w_b = i_rot_sin;
            end
            OP_RS_CS: begin
                w_a = {{(MUL_A_W-COEF_W){r_ps[COEF_W-1]}}, r_ps};
                w_b = i_rot_cos;
            end
            OP_RS_SC: begin
                w_a = {{(MUL_A_W-COEF_W){r_pc[COEF_W-1]}}, r_pc};
                w_b = i_rot_sin;
            end
            OP_GAIN: begin
                w_a = r_t;
                w_b = {{(MUL_B_W-GAIN_W){i_gain[GAIN_W-1]}}, i_gain};
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    // Round half up: add half an LSB, then shift arithmetically.
    assign w_pext   = {r_prod[PROD_W-1], r_prod};
    assign w_rnd17  = (w_pext + HALF17) >>> 17;
    assign w_rnd25  = (w_pext + HALF25) >>> 25;
    assign w_rnd30  = (w_pext + HALF30) >>> COEF_FRAC;
    assign w_r30    = w_rnd30[ACC_W-1:0];
    assign w_st_sum = {{(ACC_W-COEF_W){r_prev[COEF_W-1]}}, r_prev} + w_r30;
    assign w_st_new = sat32(w_st_sum);
    assign w_y      = w_rnd25[OUT_SUM_W-1:0]
                    + (r_add ? {{(OUT_SUM_W-SMP_W){r_acc[SMP_W-1]}}, r_acc} : '0);

    // Product register and write-back tag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb_en <= 1'b0;
        end else begin
            r_wb_en <= i_cmd.mul_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod   <= w_a * w_b;
            r_wb_op  <= i_cmd.op;
            r_wb_idx <= i_cmd.idx;
            r_prev   <= w_out_sel;
        end
        if (i_cmd.load) begin
            r_x   <= i_audio_in;
            r_add <= i_add_mode;
            r_acc <= i_accum_in;
        end
        if (r_wb_en) begin
            case (r_wb_op)
                OP_MD_RE: r_zr   <= w_rnd17[COEF_W-1:0];
                OP_MD_IM: r_zi   <= -w_rnd17[COEF_W-1:0];
                OP_ST_RE: r_zr   <= w_st_new;
                OP_ST_IM: r_zi   <= w_st_new;
                OP_MU_RE: r_t    <= w_r30;
                OP_MU_IM: r_t    <= r_t - w_r30;
                OP_RC_CC: r_rcos <= w_r30;
                OP_RC_SS: r_rcos <= r_rcos + w_r30;
                OP_RS_CS: r_rsin <= w_r30;
                OP_RS_SC: r_rsin <= r_rsin - w_r30;
                default: ;
            endcase
        end
        if (i_cmd.finish) begin
            r_out_data <= sat16(w_y);
        end
    end

    // Filter state: the stage input takes the value that entered the stage,
    // the stage output the smoothed value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_STAGES; i++) begin
                r_in_re[i]  <= '0;
                r_in_im[i]  <= '0;
                r_out_re[i] <= '0;
                r_out_im[i] <= '0;
            end
            r_pc        <= COEF_W'(ONE_Q30);
            r_ps        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_wb_en && (r_wb_op == OP_ST_RE)) begin
                r_in_re[r_wb_idx]  <= r_zr;
                r_out_re[r_wb_idx] <= w_st_new;
            end
            if (r_wb_en && (r_wb_op == OP_ST_IM)) begin
                r_in_im[r_wb_idx]  <= r_zi;
                r_out_im[r_wb_idx] <= w_st_new;
            end
            if (i_cmd.finish) begin
                r_pc        <= sat32(r_rcos);
                r_ps        <= sat32(r_rsin);
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_audio_out = r_out_data;
    assign o_out_free  = !r_out_valid || i_out_ready;

endmodule
`default_nettype wire

@@ rtl/gammatone_filter_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Gammatone filter top level
// Complex-baseband gammatone channel with configuration registers, a
// sequencing controller and a shared-multiplier datapath.
// ----------------------------------------------------------------------------
// The block takes no new input sample until it has finished the last one: its
// run grows with N, where N is filter_order limited to eight, four at reset.
// The pace is set by the single 35x32 signed multiplier, which forms one
// product per cycle: two for the mix-down, two per stage, two for the mix-up,
// four for the phasor rotation and one for the gain. A new sample is accepted
// while the previous result still waits in the output register; the sample
// then finishes only once that register has been emptied. Configuration
// writes take effect on the next clock and belong between samples.
module gammatone_filter_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [31:0]                        s_axis_tdata,  // audio_in, accum_in
    input  logic [0:0]                         s_axis_tuser,  // add_mode
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [15:0]                        m_axis_tdata,  // audio_out
    input  logic                               i_cfg_we,
    input  logic [gtf_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [gtf_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import gtf_pkg::*;

    localparam int CLAMP_W = (ORDER_W > STG_CW) ? ORDER_W : STG_CW;

    logic [ORDER_W-1:0]        r_order;
    logic [DECAY_W-1:0]        r_decay;
    logic signed [COEF_W-1:0]  r_rot_cos;
    logic signed [COEF_W-1:0]  r_rot_sin;
    logic signed [GAIN_W-1:0]  r_gain;

    logic [CLAMP_W-1:0]        w_order_ext;
    logic [STG_CW-1:0]         w_order;
    logic [DECAY_W-1:0]        w_decay;
    logic                      w_out_free;
    logic signed [SMP_W-1:0]   w_audio_out;
    t_dp_cmd                   w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order   <= ORDER_W'(4);
            r_decay   <= DECAY_W'(107374182);
            r_rot_cos <= COEF_W'(ONE_Q30);
            r_rot_sin <= '0;
            r_gain    <= GAIN_W'(4096);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ORDER:   r_order   <= i_cfg_data[ORDER_W-1:0];
                REG_DECAY:   r_decay   <= i_cfg_data[DECAY_W-1:0];
                REG_ROT_COS: r_rot_cos <= i_cfg_data[COEF_W-1:0];
                REG_ROT_SIN: r_rot_sin <= i_cfg_data[COEF_W-1:0];
                REG_GAIN:    r_gain    <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Orders above the stage count run all stages; decay saturates at one.
    assign w_order_ext = CLAMP_W'(r_order);
    assign w_order     = (w_order_ext > CLAMP_W'(MAX_STAGES)) ? STG_CW'(MAX_STAGES)
                                                               : STG_CW'(w_order_ext);
    assign w_decay     = (r_decay > ONE_Q30) ? ONE_Q30 : r_decay;

    gtf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_order    (w_order),
        .i_out_free (w_out_free),
        .o_cmd      (w_cmd)
    );

    gtf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_audio_in  (s_axis_tdata[SMP_W-1:0]),
        .i_add_mode  (s_axis_tuser[0]),
        .i_accum_in  (s_axis_tdata[2*SMP_W-1:SMP_W]),
        .i_decay     (w_decay),
        .i_rot_cos   (r_rot_cos),
        .i_rot_sin   (r_rot_sin),
        .i_gain      (r_gain),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_audio_out (w_audio_out),
        .o_out_free  (w_out_free)
    );

    assign m_axis_tdata = w_audio_out;

endmodule
`default_nettype wire

@@ rtl/gtf_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Gammatone filter port checker
// Watches the stream ports of the top level for sequencing slips.
// ----------------------------------------------------------------------------
module gtf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // Once a sample is taken the block is busy with it.
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready right after an input transfer");

    // Even with no stages the sample needs the full fixed sequence.
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |-> ##10 !s_axis_tready)
        else $error("sample finished faster than the product sequence allows");

    // A new result only appears at the end of a sample's processing.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared while the block was idle");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("output result dropped or changed while stalled");

endmodule

bind gammatone_filter_top gtf_checker u_gtf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
